// File: rtl/core/upe_pkg.sv
// Shared types, character constants and classification functions for the percent encoder.
package upe_pkg;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    localparam int unsigned ADDR_WIDTH = 3;
    localparam int unsigned DATA_WIDTH = 32;

    typedef enum logic
    {
        REG_PUNCT_ESCAPE  = 1'b0,
        REG_HEX_LOWERCASE = 1'b1
    } reg_index_t;

    typedef enum logic [1:0]
    {
        PH_PCT = 2'd0,
        PH_HI  = 2'd1,
        PH_LO  = 2'd2
    } phase_t;

    typedef struct packed
    {
        logic [7:0] data;
        logic       esc;
    } class_item_t;

    typedef struct packed
    {
        logic [7:0] data;
        logic       esc;
        logic [7:0] hi_char;
        logic [7:0] lo_char;
    } hex_item_t;

    function automatic logic is_unreserved(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
            ((c >= 8'h61) && (c <= 8'h7A)) || (c == 8'h2D) || (c == 8'h5F) ||
            (c == 8'h2E) || (c == 8'h7E);
        return r;
    endfunction

    function automatic logic is_reserved(input logic [7:0] c);
        logic r;
        case (c)
            8'h21, 8'h2A, 8'h27, 8'h28, 8'h29, 8'h3B, 8'h3A, 8'h40, 8'h26, 8'h3D,
            8'h2B, 8'h24, 8'h2C, 8'h2F, 8'h3F, 8'h25, 8'h23, 8'h5B, 8'h5D:
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
        logic [7:0] r;
        if (nib < 4'd10)
        begin
            r = CHAR_ZERO + {4'b0000, nib};
        end
        else
        begin
            r = (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + {4'b0000, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/url_percent_encoder.sv
// Top level of the percent encoder: input register, configuration registers and stage chain.
// The first character of a transaction is registered in the input register, the classify
// stage, the hex stage and the serializer before it appears on the output.
// Throughput: one input per cycle for literal bytes while out_ready stays high; an escaped
// byte holds the serializer until its three characters are out and stalls the stages behind it.
// Reset: pipeline empties, punct_escape resets to 1 and hex_lowercase to 0.
module url_percent_encoder
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [upe_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [upe_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic [upe_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic                             run_last
);

    logic                 punct_escape_reg;
    logic                 punct_escape_next;
    logic                 hex_lowercase_reg;
    logic                 hex_lowercase_next;
    logic                 cfg_write;
    upe_pkg::reg_index_t  cfg_index;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [7:0]           in_byte_reg;

    logic                 cls_in_ready;
    logic                 cls_valid;
    upe_pkg::class_item_t cls_item;
    logic                 hex_in_ready;
    logic                 hex_valid;
    upe_pkg::hex_item_t   hex_item;
    logic                 ser_in_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = upe_pkg::reg_index_t'(paddr[2]);

    always_comb
    begin
        punct_escape_next  = punct_escape_reg;
        hex_lowercase_next = hex_lowercase_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                upe_pkg::REG_PUNCT_ESCAPE:  punct_escape_next  = pwdata[0];
                upe_pkg::REG_HEX_LOWERCASE: hex_lowercase_next = pwdata[0];
                default:                    punct_escape_next  = punct_escape_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            upe_pkg::REG_PUNCT_ESCAPE:
                prdata = {{(upe_pkg::DATA_WIDTH-1){1'b0}}, punct_escape_reg};
            default:
                prdata = {{(upe_pkg::DATA_WIDTH-1){1'b0}}, hex_lowercase_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            punct_escape_reg  <= 1'b1;
            hex_lowercase_reg <= 1'b0;
        end
        else
        begin
            punct_escape_reg  <= punct_escape_next;
            hex_lowercase_reg <= hex_lowercase_next;
        end
    end

    assign in_ready      = !in_valid_reg || cls_in_ready;
    assign in_valid_next = in_ready ? in_valid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
    end

    upe_classify u_classify
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .punct_escape (punct_escape_reg),
        .in_valid     (in_valid_reg),
        .in_ready     (cls_in_ready),
        .in_data      (in_byte_reg),
        .out_valid    (cls_valid),
        .out_ready    (hex_in_ready),
        .out_item     (cls_item)
    );

    upe_hexgen u_hexgen
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .hex_lowercase (hex_lowercase_reg),
        .in_valid      (cls_valid),
        .in_ready      (hex_in_ready),
        .in_item       (cls_item),
        .out_valid     (hex_valid),
        .out_ready     (ser_in_ready),
        .out_item      (hex_item)
    );

    upe_serializer u_serializer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hex_valid),
        .in_ready  (ser_in_ready),
        .in_item   (hex_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule

// File: rtl/core/upe_classify.sv
// Pipeline stage that decides whether a byte passes literally or is escaped.
module upe_classify
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      punct_escape,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output upe_pkg::class_item_t      out_item
);

    logic                 valid_reg;
    logic                 valid_next;
    upe_pkg::class_item_t item_reg;
    upe_pkg::class_item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next     = in_ready ? in_valid : valid_reg;
        item_next.data = in_data;
        item_next.esc  = !(upe_pkg::is_unreserved(in_data) ||
                           (upe_pkg::is_reserved(in_data) && !punct_escape));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: rtl/core/upe_hexgen.sv
// Pipeline stage that forms the two hex digit characters of a byte.
module upe_hexgen
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      hex_lowercase,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  upe_pkg::class_item_t      in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output upe_pkg::hex_item_t        out_item
);

    logic               valid_reg;
    logic               valid_next;
    upe_pkg::hex_item_t item_reg;
    upe_pkg::hex_item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next        = in_ready ? in_valid : valid_reg;
        item_next.data    = in_item.data;
        item_next.esc     = in_item.esc;
        item_next.hi_char = upe_pkg::hex_char(in_item.data[7:4], hex_lowercase);
        item_next.lo_char = upe_pkg::hex_char(in_item.data[3:0], hex_lowercase);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: rtl/core/upe_serializer.sv
// Output stage that emits one literal character or the three characters of an escape.
module upe_serializer
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  upe_pkg::hex_item_t        in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_byte,
    output logic                      run_last
);

    logic               valid_reg;
    logic               valid_next;
    upe_pkg::phase_t    phase_reg;
    upe_pkg::phase_t    phase_next;
    upe_pkg::hex_item_t item_reg;
    logic               last_now;
    logic               take;

    assign last_now = !item_reg.esc || (phase_reg == upe_pkg::PH_LO);
    assign take     = !valid_reg || (out_ready && last_now);
    assign in_ready = take;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (take)
        begin
            valid_next = in_valid;
            phase_next = upe_pkg::PH_PCT;
        end
        else if (out_ready)
        begin
            unique case (phase_reg)
                upe_pkg::PH_PCT: phase_next = upe_pkg::PH_HI;
                upe_pkg::PH_HI:  phase_next = upe_pkg::PH_LO;
                default:         phase_next = upe_pkg::PH_PCT;
            endcase
        end
    end

    always_comb
    begin
        out_byte = item_reg.data;
        if (item_reg.esc)
        begin
            unique case (phase_reg)
                upe_pkg::PH_PCT: out_byte = upe_pkg::CHAR_PERCENT;
                upe_pkg::PH_HI:  out_byte = item_reg.hi_char;
                default:         out_byte = item_reg.lo_char;
            endcase
        end
        out_valid = valid_reg;
        run_last  = last_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= upe_pkg::PH_PCT;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
        begin
            item_reg <= in_item;
        end
    end

`ifndef ASSERT_OFF
    a_escape_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !run_last) |=> out_valid)
        else $error("Escape sequence was cut short.");

    a_phase_only_escaped: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (phase_reg != upe_pkg::PH_PCT)) |-> item_reg.esc)
        else $error("Literal character advanced past its first phase.");

    a_phase_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && run_last) |=> (phase_reg == upe_pkg::PH_PCT))
        else $error("Phase did not restart after the last character.");

    a_hi_follows_pct: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && (phase_reg == upe_pkg::PH_PCT) && item_reg.esc)
        |=> (phase_reg == upe_pkg::PH_HI))
        else $error("High digit did not follow the percent sign.");
`endif

endmodule

// File: tb/tb_url_percent_encoder.sv
// Self-checking testbench for url_percent_encoder: random byte stream, APB setup, scoreboard.
module tb_url_percent_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ADDR_WIDTH = upe_pkg::ADDR_WIDTH;
    localparam int unsigned DATA_WIDTH = upe_pkg::DATA_WIDTH;

    localparam int CLK_PERIOD  = 12;
    localparam int LONG_HOLD   = 120;
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_UNRES   = 66;
    localparam int NUM_RES     = 19;

    localparam logic [8*NUM_UNRES-1:0] UNRESERVED_SET =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-_.~";
    localparam logic [8*NUM_RES-1:0] RESERVED_SET = "!*'();:@&=+$,/?%#[]";
    localparam logic [127:0] HEX_UPPER = "0123456789ABCDEF";
    localparam logic [127:0] HEX_LOWER = "0123456789abcdef";

    typedef struct packed
    {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [DATA_WIDTH-1:0] pwdata = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            in_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            out_byte;
    logic                  run_last;

    logic [7:0] raw_byte_q[$];
    enc_char_t  encoded_char_q[$];

    logic punct_escape_cfg = 1'b1;
    logic hex_lowercase_cfg = 1'b0;
    bit   send_gaps = 1'b1;
    bit   recv_gaps = 1'b1;
    bit   long_hold_req = 1'b0;
    int   send_gap_cnt = 0;
    int   recv_hold_cnt = 0;
    int   stall_cycles = 0;
    int   mismatch_count = 0;

    logic [7:0] corner_bytes[] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h20, "%", "A", "Z",
                                   "a", "z", "0", "9", "-", "_", ".", "~", "!", "]", "/",
                                   "?", 8'hA5};

    url_percent_encoder i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    function automatic bit char_in_set(input logic [7:0] c,
                                       input logic [8*NUM_UNRES-1:0] set,
                                       input int count);
        for (int k = 0; k < count; k++)
        begin
            if (set[k*8 +: 8] == c)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_encoding(input logic [7:0] c);
        logic [127:0] digits;
        bit           literal;
        literal = char_in_set(c, UNRESERVED_SET, NUM_UNRES) ||
                  (char_in_set(c, (8*NUM_UNRES)'(RESERVED_SET), NUM_RES) &&
                   !punct_escape_cfg);
        digits = hex_lowercase_cfg ? HEX_LOWER : HEX_UPPER;
        if (literal)
        begin
            encoded_char_q.push_back('{ch: c, last: 1'b1});
        end
        else
        begin
            encoded_char_q.push_back('{ch: upe_pkg::CHAR_PERCENT, last: 1'b0});
            encoded_char_q.push_back('{ch: digits[(15 - c[7:4])*8 +: 8], last: 1'b0});
            encoded_char_q.push_back('{ch: digits[(15 - c[3:0])*8 +: 8], last: 1'b1});
        end
    endfunction

    function automatic logic [7:0] pick_raw_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2: b = UNRESERVED_SET[$urandom_range(0, NUM_UNRES - 1)*8 +: 8];
            3, 4, 5: b = RESERVED_SET[$urandom_range(0, NUM_RES - 1)*8 +: 8];
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            raw_byte_q.push_back(pick_raw_byte());
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (raw_byte_q.size() != 0 || in_valid || encoded_char_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic apb_write(input upe_pkg::reg_index_t idx, input logic bit_value);
        logic [DATA_WIDTH-1:0] value;
        value = $urandom();
        value[0] = bit_value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == upe_pkg::REG_PUNCT_ESCAPE)
        begin
            punct_escape_cfg = bit_value;
        end
        else
        begin
            hex_lowercase_cfg = bit_value;
        end
        @(negedge clk);
    endtask

    // Sender: presents queued bytes, holding each until the transaction completes.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_encoding(in_byte);
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap_cnt != 0)
                begin
                    send_gap_cnt--;
                    in_valid <= 1'b0;
                end
                else if (raw_byte_q.size() != 0 && send_gaps && $urandom_range(0, 5) == 0)
                begin
                    send_gap_cnt = $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end
                else if (raw_byte_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= raw_byte_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each output transaction and applies backpressure.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (encoded_char_q.size() == 0)
                begin
                    $error("unexpected transaction: out_byte %h run_last %b", out_byte, run_last);
                    mismatch_count++;
                end
                else
                begin
                    if (out_byte !== encoded_char_q[0].ch)
                    begin
                        $error("out_byte mismatch: expected %h, actual %h",
                               encoded_char_q[0].ch, out_byte);
                        mismatch_count++;
                    end
                    if (run_last !== encoded_char_q[0].last)
                    begin
                        $error("run_last mismatch: expected %b, actual %b",
                               encoded_char_q[0].last, run_last);
                        mismatch_count++;
                    end
                    void'(encoded_char_q.pop_front());
                end
            end
            if (recv_hold_cnt != 0)
            begin
                recv_hold_cnt--;
                out_ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                recv_hold_cnt = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gaps && $urandom_range(0, 5) == 0)
            begin
                recv_hold_cnt = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (raw_byte_q.size() == 0 && encoded_char_q.size() == 0 && !in_valid))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        bit phase_escape[4];
        bit phase_lower[4];
        phase_escape = '{1'b1, 1'b0, 1'b1, 1'b0};
        phase_lower  = '{1'b0, 1'b0, 1'b1, 1'b1};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (corner_bytes[k])
        begin
            raw_byte_q.push_back(corner_bytes[k]);
        end
        wait_drained();

        // Escaped bytes under a long output stall fill the pipeline and block the input.
        apb_write(upe_pkg::REG_PUNCT_ESCAPE, 1'b1);
        long_hold_req = 1'b1;
        for (int n = 0; n < 40; n++)
        begin
            raw_byte_q.push_back(8'($urandom_range(0, 255)) | 8'h80);
        end
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            if (p % 2 == 0)
            begin
                apb_write(upe_pkg::REG_PUNCT_ESCAPE, phase_escape[p]);
                apb_write(upe_pkg::REG_HEX_LOWERCASE, phase_lower[p]);
            end
            else
            begin
                apb_write(upe_pkg::REG_HEX_LOWERCASE, phase_lower[p]);
                apb_write(upe_pkg::REG_PUNCT_ESCAPE, phase_escape[p]);
            end
            send_gaps = (p != 2);
            recv_gaps = (p != 1);
            raw_byte_q.push_back("%");
            raw_byte_q.push_back(8'h00);
            raw_byte_q.push_back(8'hFF);
            queue_random(32);
            wait_drained();
            queue_random(35);
            wait_drained();
        end

        apb_write(upe_pkg::REG_HEX_LOWERCASE, 1'b0);
        apb_write(upe_pkg::REG_PUNCT_ESCAPE, 1'b0);
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        queue_random(40);
        wait_drained();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && encoded_char_q.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
